>>> hdl/efg_pkg.sv
// Shared constants for the envelope follower gate: bus geometry, register map and reset values.
`timescale 1ns / 1ps

package efg_pkg;

    // Configuration bus geometry.
    localparam int APB_DATA_BITS = 32;
    localparam int APB_ADDR_BITS = 4;

    // Register indexes; byte address is 4 times the index.
    localparam logic [1:0] REG_ATTACK_COEFF     = 2'd0;
    localparam logic [1:0] REG_RELEASE_COEFF    = 2'd1;
    localparam logic [1:0] REG_GATE_THRESHOLD   = 2'd2;
    localparam logic [1:0] REG_HYSTERESIS_RATIO = 2'd3;

    // Reset values before truncation to the configured widths.
    localparam logic [31:0] ATTACK_COEFF_RESET     = 32'd148;
    localparam logic [31:0] RELEASE_COEFF_RESET    = 32'd15;
    localparam logic [31:0] GATE_THRESHOLD_RESET   = 32'd3277;
    localparam logic [31:0] HYSTERESIS_RATIO_RESET = 32'd45875;

endpackage

>>> hdl/efg_step.sv
// Combinational envelope update and hysteresis gate decision for one sample.
`timescale 1ns / 1ps

module efg_step #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEFF_BITS  = 16
) (
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [SAMPLE_BITS-1:0] envelope,
    input  logic                          gate,
    input  logic        [COEFF_BITS-1:0]  attack_coeff,
    input  logic        [COEFF_BITS-1:0]  release_coeff,
    input  logic        [SAMPLE_BITS-1:0] gate_threshold,
    input  logic        [SAMPLE_BITS-1:0] release_level,
    output logic        [SAMPLE_BITS-1:0] envelope_next,
    output logic                          gate_next
);

    localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;

    logic [SAMPLE_BITS-1:0] rect;
    logic                   rising;
    logic                   upward;
    logic [SAMPLE_BITS-1:0] diff;
    logic [COEFF_BITS-1:0]  coeff;
    logic [PROD_BITS-1:0]   prod;
    logic [PROD_BITS:0]     prod_round;
    logic [SAMPLE_BITS-1:0] step_up;
    logic [SAMPLE_BITS-1:0] step_down;

    always_comb
    begin
        // The most negative sample maps to 2^(SAMPLE_BITS-1), which still fits unsigned.
        rect   = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
        rising = rect > envelope;
        upward = rect >= envelope;
        diff   = upward ? (rect - envelope) : (envelope - rect);
        coeff  = rising ? attack_coeff : release_coeff;
        prod   = PROD_BITS'(coeff) * PROD_BITS'(diff);
        // A falling step rounds its magnitude up so the signed update floors.
        prod_round = {1'b0, prod} + (PROD_BITS + 1)'({COEFF_BITS{1'b1}});
        step_up    = prod[PROD_BITS-1:COEFF_BITS];
        step_down  = prod_round[PROD_BITS-1:COEFF_BITS];
        envelope_next = upward ? (envelope + step_up) : (envelope - step_down);

        if (!gate)
        begin
            gate_next = envelope_next > gate_threshold;
        end
        else
        begin
            gate_next = !(envelope_next < release_level);
        end
    end

endmodule

>>> hdl/envelope_follower_gate_top.sv
// Top level of the envelope follower gate: register port, input and result stages.
`timescale 1ns / 1ps

// The block takes one signed sample per transfer and returns the smoothed rectified
// envelope with the hysteresis gate flag, one result for every sample. It sustains one
// sample per clock cycle while result_stall is low; a sample passes the input register,
// then the result register. The rate is set by the envelope recurrence, a single
// multiply-add whose result feeds the next sample. The release level, threshold times
// hysteresis ratio, is kept in a register fed from the threshold and ratio registers.
// Registers sit at byte addresses 0, 4, 8 and 12: attack coefficient, release
// coefficient, gate threshold and hysteresis ratio; they may be read back at any time.
module envelope_follower_gate_top #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEFF_BITS  = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [efg_pkg::APB_ADDR_BITS-1:0]    paddr,
    input  logic [efg_pkg::APB_DATA_BITS-1:0]    pwdata,
    output logic [efg_pkg::APB_DATA_BITS-1:0]    prdata,
    output logic                                 pready,
    input  logic signed [SAMPLE_BITS-1:0]        sample,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    output logic [SAMPLE_BITS-1:0]               envelope_level,
    output logic                                 gate_active,
    output logic                                 result_valid,
    input  logic                                 result_stall
);

    localparam int PROD_BITS = SAMPLE_BITS + COEFF_BITS;

    logic [COEFF_BITS-1:0]   attack_coeff_reg;
    logic [COEFF_BITS-1:0]   release_coeff_reg;
    logic [SAMPLE_BITS-1:0]  gate_threshold_reg;
    logic [COEFF_BITS-1:0]   hysteresis_ratio_reg;
    logic [SAMPLE_BITS-1:0]  release_level_reg;
    logic [PROD_BITS-1:0]    release_prod;

    logic                    cfg_write;
    logic [1:0]              cfg_index;

    logic                    in_valid_reg;
    logic signed [SAMPLE_BITS-1:0] in_sample_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  envelope_reg;
    logic                    gate_reg;
    logic [SAMPLE_BITS-1:0]  envelope_next;
    logic                    gate_next;

    logic                    out_free;
    logic                    advance;
    logic                    take_in;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coeff_reg     <= COEFF_BITS'(efg_pkg::ATTACK_COEFF_RESET);
            release_coeff_reg    <= COEFF_BITS'(efg_pkg::RELEASE_COEFF_RESET);
            gate_threshold_reg   <= SAMPLE_BITS'(efg_pkg::GATE_THRESHOLD_RESET);
            hysteresis_ratio_reg <= COEFF_BITS'(efg_pkg::HYSTERESIS_RATIO_RESET);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                efg_pkg::REG_ATTACK_COEFF:     attack_coeff_reg     <= pwdata[COEFF_BITS-1:0];
                efg_pkg::REG_RELEASE_COEFF:    release_coeff_reg    <= pwdata[COEFF_BITS-1:0];
                efg_pkg::REG_GATE_THRESHOLD:   gate_threshold_reg   <= pwdata[SAMPLE_BITS-1:0];
                efg_pkg::REG_HYSTERESIS_RATIO: hysteresis_ratio_reg <= pwdata[COEFF_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            efg_pkg::REG_ATTACK_COEFF:
                prdata = efg_pkg::APB_DATA_BITS'(attack_coeff_reg);
            efg_pkg::REG_RELEASE_COEFF:
                prdata = efg_pkg::APB_DATA_BITS'(release_coeff_reg);
            efg_pkg::REG_GATE_THRESHOLD:
                prdata = efg_pkg::APB_DATA_BITS'(gate_threshold_reg);
            efg_pkg::REG_HYSTERESIS_RATIO:
                prdata = efg_pkg::APB_DATA_BITS'(hysteresis_ratio_reg);
            default:
                prdata = '0;
        endcase
    end

    // The release level only changes with configuration, so it gets its own register.
    assign release_prod = PROD_BITS'(gate_threshold_reg) * PROD_BITS'(hysteresis_ratio_reg);

    always_ff @(posedge clk)
    begin
        release_level_reg <= release_prod[PROD_BITS-1:COEFF_BITS];
    end

    // Stage control: the result register frees up when empty or when its transfer completes.
    assign out_free     = !out_valid_reg || !result_stall;
    assign advance      = in_valid_reg && out_free;
    assign sample_stall = in_valid_reg && !out_free;
    assign take_in      = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            envelope_reg  <= '0;
            gate_reg      <= 1'b0;
        end
        else
        begin
            if (take_in)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                envelope_reg  <= envelope_next;
                gate_reg      <= gate_next;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_sample_reg <= sample;
        end
    end

    // The result register doubles as the filter state.
    efg_step #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEFF_BITS  (COEFF_BITS)
    ) u_step (
        .sample         (in_sample_reg),
        .envelope       (envelope_reg),
        .gate           (gate_reg),
        .attack_coeff   (attack_coeff_reg),
        .release_coeff  (release_coeff_reg),
        .gate_threshold (gate_threshold_reg),
        .release_level  (release_level_reg),
        .envelope_next  (envelope_next),
        .gate_next      (gate_next)
    );

    assign envelope_level = envelope_reg;
    assign gate_active    = gate_reg;
    assign result_valid   = out_valid_reg;

endmodule
